### rtl/heap_sort_engine_macros.svh
// Assertion macros shared by the checker files of the heap sort engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define HSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap sort engine: next-cycle check failed");

// The expression must never be true outside reset.
`define HSE_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("heap sort engine: forbidden condition seen");

`endif

### rtl/hse_pkg.sv
// Package of the heap sort engine: sizes, select codes and the command and
// status structs between controller and datapath. No dependencies.
package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CHILD_W   = ADDR_W + 2;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_IN,
        WR_V,
        WR_SIFT,
        WR_ROOT
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_BUILD,
        RD_CHILD,
        RD_EXTRACT,
        RD_OUT
    } rd_sel_t;

    typedef struct packed {
        logic    in_ready;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        logic    load_node;
        logic    load_v;
        logic    sift_step;
        logic    extract_swap;
        logic    build_dec;
        logic    load_out;
        logic    next_out;
        logic    clear_set;
    } hse_cmd_t;

    typedef struct packed {
        logic last_fire;
        logic heap_one;
        logic has_child;
        logic go_down;
        logic build_zero;
        logic out_fire;
        logic out_last;
    } hse_status_t;

endpackage

### rtl/hse_datapath.sv
// Datapath of the heap sort engine: element memory, heap indexes, sift
// comparator and output register. Depends on hse_pkg.
module hse_datapath
    import hse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hse_cmd_t                 cmd,
    output hse_status_t              status,
    input  logic                     s_tvalid,
    input  logic signed [DATA_W-1:0] s_tdata,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,
    output logic                     m_tlast,
    output logic                     m_tuser
);

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];

    logic [CNT_W-1:0]         count_reg;
    logic                     dropped_reg;
    logic                     out_valid_reg;
    logic [CNT_W-1:0]         size_reg;
    logic [CNT_W-1:0]         total_reg;
    logic [ADDR_W-1:0]        build_reg;
    logic [ADDR_W-1:0]        node_reg;
    logic [ADDR_W-1:0]        out_idx_reg;
    logic signed [DATA_W-1:0] v_reg;
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_last_reg;
    logic                     out_ovf_reg;

    logic                     in_fire;
    logic                     full;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         count_dec;
    logic [CHILD_W-1:0]       child;
    logic [CHILD_W-1:0]       right;
    logic [CHILD_W-1:0]       size_ext;
    logic                     right_ok;
    logic signed [DATA_W-1:0] cmax;
    logic [ADDR_W-1:0]        cidx;
    logic                     go_down;
    logic [CNT_W-1:0]         size_dec;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0]        rd_a_addr;
    logic [ADDR_W-1:0]        rd_b_addr;
    logic                     out_fire;

    assign in_fire    = s_tvalid && cmd.in_ready;
    assign full       = (count_reg == CNT_W'(MAX_ITEMS));
    assign count_next = full ? count_reg : count_reg + CNT_W'(1);
    assign count_dec  = count_next - CNT_W'(1);
    assign size_dec   = size_reg - CNT_W'(1);
    assign out_fire   = out_valid_reg && m_tready;

    assign child    = CHILD_W'({node_reg, 1'b1});
    assign right    = child + CHILD_W'(1);
    assign size_ext = CHILD_W'(size_reg);
    assign right_ok = (right < size_ext) && (rd_a_reg < rd_b_reg);
    assign cmax     = right_ok ? rd_b_reg : rd_a_reg;
    assign cidx     = right_ok ? right[ADDR_W-1:0] : child[ADDR_W-1:0];
    assign go_down  = (v_reg < cmax);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = v_reg;
        unique case (cmd.wr_sel)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_IN:
            begin
                wr_en   = in_fire && !full;
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = s_tdata;
            end
            WR_V:
            begin
                wr_en = 1'b1;
            end
            WR_SIFT:
            begin
                wr_en   = 1'b1;
                wr_data = go_down ? cmax : v_reg;
            end
            WR_ROOT:
            begin
                wr_en   = 1'b1;
                wr_addr = size_dec[ADDR_W-1:0];
                wr_data = rd_a_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_BUILD:
            begin
                rd_a_addr = build_reg;
                rd_b_addr = build_reg;
            end
            RD_CHILD:
            begin
                rd_a_addr = child[ADDR_W-1:0];
                rd_b_addr = right[ADDR_W-1:0];
            end
            RD_EXTRACT:
            begin
                rd_a_addr = '0;
                rd_b_addr = size_dec[ADDR_W-1:0];
            end
            RD_OUT:
            begin
                rd_a_addr = out_idx_reg;
                rd_b_addr = out_idx_reg;
            end
            default:
            begin
                rd_a_addr = out_idx_reg;
                rd_b_addr = out_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_set)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                count_reg <= count_next;
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            size_reg    <= count_next;
            total_reg   <= count_next;
            build_reg   <= count_dec[ADDR_W:1];
            out_idx_reg <= '0;
        end
        if (cmd.load_node)
        begin
            node_reg <= build_reg;
        end
        if (cmd.load_v)
        begin
            v_reg <= rd_a_reg;
        end
        if (cmd.sift_step && go_down)
        begin
            node_reg <= cidx;
        end
        if (cmd.extract_swap)
        begin
            v_reg    <= rd_b_reg;
            size_reg <= size_dec;
            node_reg <= '0;
        end
        if (cmd.build_dec)
        begin
            build_reg <= build_reg - ADDR_W'(1);
        end
        if (cmd.load_out)
        begin
            out_data_reg <= rd_a_reg;
            out_last_reg <= (CNT_W'(out_idx_reg) + CNT_W'(1) == total_reg);
            out_ovf_reg  <= dropped_reg;
        end
        if (cmd.next_out)
        begin
            out_idx_reg <= out_idx_reg + ADDR_W'(1);
        end
    end

    assign status.last_fire  = in_fire && s_tlast;
    assign status.heap_one   = (size_reg == CNT_W'(1));
    assign status.has_child  = (child < size_ext);
    assign status.go_down    = go_down;
    assign status.build_zero = (build_reg == '0);
    assign status.out_fire   = out_fire;
    assign status.out_last   = out_last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

### rtl/hse_ctrl.sv
// Controller of the heap sort engine: sequences collection, heap build,
// extraction and readout. Depends on hse_pkg.
module hse_ctrl
    import hse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hse_status_t status,
    output hse_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_START,
        ST_BUILD_RD,
        ST_BUILD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_SIFT_END,
        ST_EXTRACT_RD,
        ST_EXTRACT_SW,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t state_reg;
    logic   extract_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            extract_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (status.last_fire)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    extract_reg <= 1'b0;
                    state_reg   <= status.heap_one ? ST_OUT_RD : ST_BUILD_RD;
                end
                ST_BUILD_RD:
                begin
                    state_reg <= ST_BUILD_LD;
                end
                ST_BUILD_LD:
                begin
                    state_reg <= ST_SIFT_RD;
                end
                ST_SIFT_RD:
                begin
                    state_reg <= status.has_child ? ST_SIFT_CMP : ST_SIFT_END;
                end
                ST_SIFT_CMP:
                begin
                    state_reg <= status.go_down ? ST_SIFT_RD : ST_SIFT_END;
                end
                ST_SIFT_END:
                begin
                    if (extract_reg)
                    begin
                        state_reg <= status.heap_one ? ST_OUT_RD : ST_EXTRACT_RD;
                    end
                    else if (status.build_zero)
                    begin
                        extract_reg <= 1'b1;
                        state_reg   <= ST_EXTRACT_RD;
                    end
                    else
                    begin
                        state_reg <= ST_BUILD_RD;
                    end
                end
                ST_EXTRACT_RD:
                begin
                    state_reg <= ST_EXTRACT_SW;
                end
                ST_EXTRACT_SW:
                begin
                    state_reg <= ST_SIFT_RD;
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    state_reg <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (status.out_fire)
                    begin
                        state_reg <= status.out_last ? ST_COLLECT : ST_OUT_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.wr_sel       = WR_NONE;
        cmd.rd_sel       = RD_OUT;
        unique case (state_reg)
            ST_COLLECT:
            begin
                cmd.in_ready = 1'b1;
                cmd.wr_sel   = WR_IN;
            end
            ST_START:
            begin
                cmd.rd_sel = RD_BUILD;
            end
            ST_BUILD_RD:
            begin
                cmd.rd_sel    = RD_BUILD;
                cmd.load_node = 1'b1;
            end
            ST_BUILD_LD:
            begin
                cmd.load_v = 1'b1;
            end
            ST_SIFT_RD:
            begin
                cmd.rd_sel = RD_CHILD;
                if (!status.has_child)
                begin
                    cmd.wr_sel = WR_V;
                end
            end
            ST_SIFT_CMP:
            begin
                cmd.wr_sel    = WR_SIFT;
                cmd.sift_step = 1'b1;
            end
            ST_SIFT_END:
            begin
                cmd.build_dec = !extract_reg && !status.build_zero;
            end
            ST_EXTRACT_RD:
            begin
                cmd.rd_sel = RD_EXTRACT;
            end
            ST_EXTRACT_SW:
            begin
                cmd.rd_sel       = RD_EXTRACT;
                cmd.wr_sel       = WR_ROOT;
                cmd.extract_swap = 1'b1;
            end
            ST_OUT_RD:
            begin
                cmd.rd_sel = RD_OUT;
            end
            ST_OUT_LD:
            begin
                cmd.load_out = 1'b1;
            end
            ST_OUT_WAIT:
            begin
                cmd.next_out  = status.out_fire && !status.out_last;
                cmd.clear_set = status.out_fire && status.out_last;
            end
            default:
            begin
                cmd.wr_sel = WR_NONE;
            end
        endcase
    end

endmodule

### rtl/heap_sort_engine.sv
// Heap sort engine: one input transfer per cycle while collecting a set of n items.
// The heap build runs about n/2 sifts and the extraction n-1. Input is held off from the
// last item until the last result; readout steps through a read, a load and a wait
// state for each result. Reset clears the count, the dropped flag and the output
// valid; the element memory is not cleared.
module heap_sort_engine
    import hse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,  // [31:0] sorted_value
    output logic                     m_tlast,
    output logic                     m_tuser   // [0] overflow
);

    hse_cmd_t    cmd;
    hse_status_t status;

    hse_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.in_ready;

endmodule

### rtl/hse_checker.sv
// Port-level checker of the heap sort engine, bound to the top level.
// Depends on heap_sort_engine_macros.svh.
`include "heap_sort_engine_macros.svh"

module hse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    `HSE_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)
    `HSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `HSE_ASSERT_NEXT(a_ready_after_run, m_tvalid && m_tready && m_tlast, s_tready)
    `HSE_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for heap_sort_engine: directed stimulus table, then random sets.
// Uses hse_pkg for sizes; stream handshakes on both sides with random idling and stalls.
module tb_top
    import hse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 1600;
    localparam int PHASE_ITEMS  = 32;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } sorted_entry_t;

    typedef struct {
        logic signed [DATA_W-1:0] base;
        int                       step;
        int                       count;
        bit                       close;
        bit                       hand;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [DATA_W-1:0] m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;

    logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
    int                       held_count = 0;
    bit                       held_lost = 1'b0;
    sorted_entry_t            sorted_queue [$];
    sorted_entry_t            want;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  mismatch_count = 0;
    int  item_total = 0;
    int  set_total = 0;
    int  result_total = 0;
    int  overflow_sets = 0;

    heap_sort_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic void predict_sorted_run(logic signed [DATA_W-1:0] v, bit l);
        logic signed [DATA_W-1:0] run [MAX_ITEMS];
        logic signed [DATA_W-1:0] key;
        int                       n;
        int                       j;
        if (held_count < MAX_ITEMS)
        begin
            held_values[held_count] = v;
            held_count++;
        end
        else
        begin
            held_lost = 1'b1;
        end
        if (l)
        begin
            n = held_count;
            for (int i = 0; i < n; i++)
            begin
                key = held_values[i];
                j = i - 1;
                while (j >= 0 && run[j] > key)
                begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = key;
            end
            for (int i = 0; i < n; i++)
            begin
                sorted_queue.push_back(sorted_entry_t'{run[i], (i == n - 1), held_lost});
            end
            set_total++;
            if (held_lost)
            begin
                overflow_sets++;
            end
            held_count = 0;
            held_lost = 1'b0;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(int mode);
        logic signed [DATA_W-1:0] v;
        case (mode)
            1: v = $signed($urandom_range(7)) - 4;
            2:
            begin
                case ($urandom_range(4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(logic signed [DATA_W-1:0] v, bit l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        item_total++;
        predict_sorted_run(v, l);
    endtask

    task automatic send_random_set(int size, int mode);
        for (int k = 0; k < size; k++)
        begin
            send_item(pick_value(mode), k == size - 1);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sorted_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_total++;
            if (sorted_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result: value %0d last %0b overflow %0b",
                             m_tdata, m_tlast, m_tuser);
                end
            end
            else
            begin
                want = sorted_queue.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.last || m_tuser !== want.ovf)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.value, want.last, want.ovf, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("heap_sort_engine test failed");
        $finish;
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        int       phase_items;
        int       size;
        int       sel;
        rows.push_back(dir_row_t'{32'sd0, 0, 1, 1'b1, 1'b1});
        rows.push_back(dir_row_t'{VAL_MAX, 0, 1, 1'b1, 1'b1});
        rows.push_back(dir_row_t'{VAL_MIN, 0, 1, 1'b1, 1'b1});
        rows.push_back(dir_row_t'{-32'sd1, 0, 1, 1'b1, 1'b1});
        rows.push_back(dir_row_t'{32'sd5, 0, 3, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{VAL_MAX, 0, 1, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{VAL_MIN, 0, 1, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{32'sd0, 0, 1, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{-32'sd1, 0, 1, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{32'sd1, 0, 1, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'sd10, -1, 2, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'sd3, 1, 2, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'hAAAAAAAA, 0, 1, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{32'h55555555, 0, 1, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'sd1000, -7, MAX_ITEMS, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{-32'sd500, 13, MAX_ITEMS, 1'b0, 1'b0});
        rows.push_back(dir_row_t'{32'sd77, 0, 1, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'h7ffffff0, 3, MAX_ITEMS + 6, 1'b1, 1'b0});
        rows.push_back(dir_row_t'{32'sd42, 0, 1, 1'b1, 1'b1});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            for (int k = 0; k < r.count; k++)
            begin
                send_item(r.base + 32'(k * r.step), r.close && (k == r.count - 1));
            end
            if (r.hand)
            begin
                void'(sorted_queue.pop_back());
                sorted_queue.push_back(sorted_entry_t'{r.base, 1'b1, 1'b0});
            end
        end
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            phase_items = 0;
            if (phase == 0)
            begin
                send_random_set(MAX_ITEMS, 0);
                hold_request = 1'b1;
            end
            while (phase_items < PHASE_ITEMS)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    size = $urandom_range(8, 1);
                else if (sel < 85)
                    size = $urandom_range(24, 9);
                else if (sel < 95)
                    size = $urandom_range(MAX_ITEMS, 25);
                else
                    size = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS + 1);
                send_random_set(size, $urandom_range(2));
                phase_items += size;
            end
            drain_results();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d items in %0d sets (%0d with dropped items), %0d results checked",
                 item_total, set_total, overflow_sets, result_total);
        $display("idling phases: none, sender gaps, receiver stalls, both; one long output hold");
        if (mismatch_count == 0 && sorted_queue.size() == 0)
        begin
            $display("heap_sort_engine test passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count, sorted_queue.size());
            $display("heap_sort_engine test failed");
        end
        $finish;
    end

endmodule
